// ===== rtl/text_console_buffer_defines.svh =====
// Assertion macros shared by the console checker.
// Depends on nothing; the including module provides clk and rst_n.
`ifndef TEXT_CONSOLE_BUFFER_DEFINES_SVH
`define TEXT_CONSOLE_BUFFER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define TCB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define TCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define TCB_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tcb_pkg.sv =====
// Shared constants for the text console buffer: request kinds, character codes,
// field widths and stream packing offsets. No dependencies.
`default_nettype none

package tcb_pkg;

  localparam int DEF_ROWS = 4;
  localparam int DEF_COLS = 21;

  // Field widths fixed by the stream format
  localparam int KIND_W = 3;
  localparam int ROW_W  = 2;
  localparam int COL_W  = 5;
  localparam int CHAR_W = 8;

  // in_tdata: row, col, char_code from bit 0 up
  localparam int IN_ROW_LSB  = 0;
  localparam int IN_COL_LSB  = IN_ROW_LSB + ROW_W;
  localparam int IN_CHAR_LSB = IN_COL_LSB + COL_W;
  localparam int IN_DATA_W   = 16;

  // out_tdata: char_value, inverted, cursor_row, cursor_col from bit 0 up
  localparam int OUT_DATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_PUT      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POKE     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INVERT   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLR_INV  = 3'd5;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

endpackage

`default_nettype wire

// ===== rtl/tcb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module tcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 84
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/text_console_buffer.sv =====
// Text console buffer top level: character memory with row rotation for scrolling,
// per-row invert marks, write cursor. Depends on tcb_pkg and tcb_ram.
//
//   channel | dir | handshake              | payload
//   in_     | in  | in_tvalid / in_tready   | tuser kind; tdata row, col, char_code
//   out_    | out | out_tvalid / out_tready | tdata char_value, inverted, cursor
//
// Put char, poke, invert, clear inverts, unused kinds and off-grid reads go straight to
// the result state; an in-grid read reads the RAM first. A put that scrolls blanks
// the new last row; a newline pads the rest of its row with spaces, and blanks on a
// scroll too; clear screen spaces every cell. After reset a pass fills RAM with spaces.
// The output register holds a result until taken; the next request is still accepted,
// but its result then holds the block until the register frees.
`default_nettype none

module text_console_buffer #(
  parameter int ROWS = tcb_pkg::DEF_ROWS,
  parameter int COLS = tcb_pkg::DEF_COLS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [tcb_pkg::KIND_W-1:0]      in_tuser,   // kind
  input  wire logic [tcb_pkg::IN_DATA_W-1:0]   in_tdata,   // row, col, char_code
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [tcb_pkg::OUT_DATA_W-1:0]  out_tdata   // char_value, inverted,
                                                           // cursor_row, cur_column
);

  import tcb_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);

  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] COLS_A     = AW'(COLS);
  localparam logic [AW-1:0] LAST_COL_A = AW'(COLS - 1);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLS - 1);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FILL  = 3'd2;
  localparam logic [2:0] ST_BLANK = 3'd3;
  localparam logic [2:0] ST_CLEAR = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  // Map a screen row to its RAM row; base_r is the RAM row shown at the top.
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
                                             input logic [RW-1:0] base);
    logic [RW:0] sum;
    sum = {1'b0, lrow} + {1'b0, base};
    if (sum >= (RW+1)'(ROWS)) begin
      sum = sum - (RW+1)'(ROWS);
    end
    return sum[RW-1:0];
  endfunction

  logic [2:0]            state_r, state_nxt;
  logic [AW-1:0]         cnt_r, cnt_nxt;
  logic [RW-1:0]         row_r, row_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [RW-1:0]         base_r, base_nxt;
  logic [RW-1:0]         blank_row_r, blank_row_nxt;
  logic [ROWS-1:0]       inv_r, inv_nxt;
  logic [CHAR_W-1:0]     res_char_r, res_char_nxt;
  logic                  res_inv_r, res_inv_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [CHAR_W-1:0] in_char;
  logic              in_accept;
  logic              req_ok;
  logic [RW-1:0]     req_row;
  logic [AW-1:0]     req_addr;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     blank_addr;
  logic [RW-1:0]     base_inc;

  logic              adv_wrap, adv_scroll;
  logic [CW-1:0]     step_col;
  logic [RW-1:0]     step_row;
  logic [RW-1:0]     step_base;
  logic [2:0]        step_wrap_state;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [CHAR_W-1:0] mem_rdata;

  assign in_row  = in_tdata[IN_ROW_LSB +: ROW_W];
  assign in_col  = in_tdata[IN_COL_LSB +: COL_W];
  assign in_char = in_tdata[IN_CHAR_LSB +: CHAR_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  assign req_ok     = (32'(in_row) < 32'(ROWS)) && (32'(in_col) < 32'(COLS));
  assign req_row    = RW'(in_row);
  assign req_addr   = AW'(phys_row(req_row, base_r)) * COLS_A + AW'(CW'(in_col));
  assign cur_addr   = AW'(phys_row(row_r, base_r)) * COLS_A + AW'(col_r);
  assign blank_addr = AW'(blank_row_r) * COLS_A + cnt_r;
  assign base_inc   = (base_r == LAST_ROW) ? '0 : base_r + RW'(1);

  // Cursor advance after one cell write; a wrap off the last row scrolls by
  // rotating the base and blanking the old top RAM row.
  assign adv_wrap        = (col_r == LAST_COL);
  assign adv_scroll      = adv_wrap && (row_r == LAST_ROW);
  assign step_col        = adv_wrap ? '0 : col_r + CW'(1);
  assign step_row        = (adv_wrap && !adv_scroll) ? row_r + RW'(1) : row_r;
  assign step_base       = adv_scroll ? base_inc : base_r;
  assign step_wrap_state = adv_scroll ? ST_BLANK : ST_DONE;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    base_nxt      = base_r;
    blank_row_nxt = blank_row_r;
    inv_nxt       = inv_r;
    res_char_nxt  = res_char_r;
    res_inv_nxt   = res_inv_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_addr;
    mem_wdata     = SPACE_CODE;

    unique case (state_r) inside
      ST_INIT, ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        cnt_nxt   = cnt_r + AW'(1);
        if (cnt_r == LAST_CELL) begin
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          res_char_nxt = '0;
          res_inv_nxt  = 1'b0;
          state_nxt    = ST_DONE;
          unique case (in_tuser)
            KIND_PUT: begin
              if (in_char == NEWLINE_CODE) begin
                state_nxt = ST_FILL;
              end else begin
                mem_we        = 1'b1;
                mem_wdata     = in_char;
                col_nxt       = step_col;
                row_nxt       = step_row;
                base_nxt      = step_base;
                blank_row_nxt = base_r;
                cnt_nxt       = '0;
                if (adv_wrap) begin
                  state_nxt = step_wrap_state;
                end
              end
            end
            KIND_POKE: begin
              if (req_ok) begin
                mem_we    = 1'b1;
                mem_waddr = req_addr;
                mem_wdata = in_char;
              end
            end
            KIND_READ: begin
              if (req_ok) begin
                res_inv_nxt = inv_r[req_row];
                state_nxt   = ST_READ;
              end
            end
            KIND_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              base_nxt  = '0;
              cnt_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            KIND_INVERT: begin
              if (32'(in_row) < 32'(ROWS)) begin
                inv_nxt[req_row] = 1'b1;
              end
            end
            KIND_CLR_INV: begin
              inv_nxt = '0;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_FILL: begin
        // Pad the rest of the row with spaces, one cell a cycle
        mem_we        = 1'b1;
        col_nxt       = step_col;
        row_nxt       = step_row;
        base_nxt      = step_base;
        blank_row_nxt = base_r;
        cnt_nxt       = '0;
        if (adv_wrap) begin
          state_nxt = step_wrap_state;
        end
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = blank_addr;
        cnt_nxt   = cnt_r + AW'(1);
        if (cnt_r == LAST_COL_A) begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        res_char_nxt = mem_rdata;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {COL_W'(col_r), ROW_W'(row_r), res_inv_r, res_char_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      base_r      <= '0;
      inv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      base_r      <= base_nxt;
      inv_r       <= inv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blank_row_r <= blank_row_nxt;
    res_char_r  <= res_char_nxt;
    res_inv_r   <= res_inv_nxt;
    out_data_r  <= out_data_nxt;
  end

  tcb_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CELLS)
  ) u_char_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(req_addr),
    .rdata(mem_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/tcb_checker.sv =====
// Port-level checks for the text console buffer, bound to the top level.
// Depends on tcb_pkg and text_console_buffer_defines.svh.
`default_nettype none
`include "text_console_buffer_defines.svh"

module tcb_checker #(
  parameter int ROWS = tcb_pkg::DEF_ROWS,
  parameter int COLS = tcb_pkg::DEF_COLS
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [tcb_pkg::OUT_DATA_W-1:0]  out_tdata   // char_value, inverted,
                                                          // cursor_row, cur_column
);

  logic cursor_ok;

  assign cursor_ok = (32'(out_tdata[10:9]) < 32'(ROWS)) && (32'(out_tdata[15:11]) < 32'(COLS));

  // Clearing pass keeps requests out right after reset
  `TCB_ASSERT_ALWAYS(a_init_blocks, !rst_n, !in_tready, "request taken during clearing pass")

  // Every request occupies the block, so no request is accepted back to back
  `TCB_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "back-to-back request")

  `TCB_ASSERT_NOW(a_cursor_range, out_tvalid, cursor_ok, "cursor off the grid")

  `TCB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind text_console_buffer tcb_checker #(
  .ROWS(ROWS),
  .COLS(COLS)
) u_tcb_checker (.*);

`default_nettype wire
